FILE: design/spc_pkg.sv
`timescale 1ns / 1ps
// Package for the sprite pixel compositor: transaction structs, stage structs,
// register index codes, fill colors and the pixel format codes.
// No dependencies.
package spc_pkg;

  // Coordinate masking width of the clip registers (default, 8..16)
  localparam int CoordBitsDef = 12;

  // Widths
  localparam int ClipW  = 12;
  localparam int PitchW = 13;
  localparam int XyW    = 18;  // pos - hot + off, full signed range
  localparam int IdxW   = 24;
  localparam int ColorW = 32;
  localparam int AddrW  = 5;

  // Register reset values
  localparam logic [ClipW-1:0]  ClipLeftRst   = 12'd0;
  localparam logic [ClipW-1:0]  ClipTopRst    = 12'd0;
  localparam logic [ClipW-1:0]  ClipRightRst  = 12'd639;
  localparam logic [ClipW-1:0]  ClipBottomRst = 12'd479;
  localparam logic [PitchW-1:0] LinePitchRst  = 13'd640;

  // Fill colors and the 5-bit channel mask of RGB555
  localparam logic [ColorW-1:0] FillRed   = 32'h00ff_0000;
  localparam logic [ColorW-1:0] FillWhite = 32'h00ff_ffff;
  localparam logic [4:0]        Chan5Mask = 5'h1f;

  // Pixel format codes
  localparam logic [1:0] FmtUnknown = 2'd0;
  localparam logic [1:0] FmtRgb555  = 2'd1;
  localparam logic [1:0] FmtRgb888  = 2'd2;

  // Register word indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_LINE_PITCH  = 3'd4
  } reg_idx_e;

  // Input transaction
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] hot_x;
    logic signed [15:0] hot_y;
    logic [11:0]        off_x;
    logic [11:0]        off_y;
    logic [31:0]        src_pixel;
    logic [1:0]         pixel_format;
    logic [31:0]        key_color;
    logic               no_data;
    logic               visible;
  } pixel_in_t;

  // Output transaction
  typedef struct packed {
    logic              write_enable;
    logic [IdxW-1:0]   write_index;
    logic [ColorW-1:0] write_color;
  } pixel_out_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [ClipW-1:0]  clip_left;
    logic [ClipW-1:0]  clip_top;
    logic [ClipW-1:0]  clip_right;
    logic [ClipW-1:0]  clip_bottom;
    logic [PitchW-1:0] line_pitch;
  } cfg_t;

  // Stage 1 -> stage 2
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic                  we_src;
    logic                  visible;
    logic [ColorW-1:0]     color;
  } s1_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    logic              we;
    logic [IdxW-1:0]   x_lo;
    logic [IdxW-1:0]   row_base;
    logic [ColorW-1:0] color;
  } s2_t;

endpackage

FILE: design/spc_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style register file for clip box and line pitch.
// Depends on spc_pkg.
module spc_cfg_regs import spc_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  // Written clip values keep min(COORD_BITS, 12) low bits
  localparam int KeepW = (COORD_BITS >= ClipW) ? ClipW : COORD_BITS;
  localparam logic [ClipW-1:0] KeepMask = ClipW'((1 << KeepW) - 1);

  logic [ClipW-1:0]  clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [PitchW-1:0] line_pitch_q;
  logic              wr_en;
  logic [ClipW-1:0]  wr_clip;
  reg_idx_e          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign wr_clip = pwdata[ClipW-1:0] & KeepMask;
  assign reg_sel = reg_idx_e'(paddr[AddrW-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= ClipLeftRst;
      clip_top_q    <= ClipTopRst;
      clip_right_q  <= ClipRightRst;
      clip_bottom_q <= ClipBottomRst;
      line_pitch_q  <= LinePitchRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CLIP_LEFT:   clip_left_q   <= wr_clip;
        REG_CLIP_TOP:    clip_top_q    <= wr_clip;
        REG_CLIP_RIGHT:  clip_right_q  <= wr_clip;
        REG_CLIP_BOTTOM: clip_bottom_q <= wr_clip;
        REG_LINE_PITCH:  line_pitch_q  <= pwdata[PitchW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_CLIP_LEFT:   prdata = {20'd0, clip_left_q};
      REG_CLIP_TOP:    prdata = {20'd0, clip_top_q};
      REG_CLIP_RIGHT:  prdata = {20'd0, clip_right_q};
      REG_CLIP_BOTTOM: prdata = {20'd0, clip_bottom_q};
      REG_LINE_PITCH:  prdata = {19'd0, line_pitch_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{clip_left:   clip_left_q,
                   clip_top:    clip_top_q,
                   clip_right:  clip_right_q,
                   clip_bottom: clip_bottom_q,
                   line_pitch:  line_pitch_q};

endmodule

FILE: design/spc_front.sv
`timescale 1ns / 1ps
// Stage 1: screen coordinates, color key test and format conversion.
// Depends on spc_pkg.
module spc_front import spc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  pixel_in_t data_i,
  output logic      stall_o,
  output logic      valid_o,
  output s1_t       data_o,
  input  logic      stall_i
);

  s1_t  data_d, data_q;
  logic valid_q;
  logic signed [XyW-1:0] pos_x_s, pos_y_s, hot_x_s, hot_y_s, off_x_s, off_y_s;
  logic [15:0] p555;

  assign pos_x_s = XyW'(data_i.pos_x);
  assign pos_y_s = XyW'(data_i.pos_y);
  assign hot_x_s = XyW'(data_i.hot_x);
  assign hot_y_s = XyW'(data_i.hot_y);
  assign off_x_s = $signed({6'd0, data_i.off_x});
  assign off_y_s = $signed({6'd0, data_i.off_y});
  assign p555    = data_i.src_pixel[15:0];

  // Coordinates and source color
  always_comb begin
    data_d.x       = pos_x_s - hot_x_s + off_x_s;
    data_d.y       = pos_y_s - hot_y_s + off_y_s;
    data_d.visible = data_i.visible;
    if (data_i.no_data) begin
      data_d.we_src = 1'b1;
      data_d.color  = FillRed;
    end else begin
      case (data_i.pixel_format)
        FmtRgb555: begin
          // bit 15 is dropped; key compares against the zero-extended pixel
          data_d.we_src = {16'd0, p555} != data_i.key_color;
          data_d.color  = {8'd0, p555[14:10] & Chan5Mask, 3'd0,
                           p555[9:5] & Chan5Mask, 3'd0,
                           p555[4:0] & Chan5Mask, 3'd0};
        end
        FmtRgb888: begin
          data_d.we_src = data_i.src_pixel != data_i.key_color;
          data_d.color  = data_i.src_pixel;
        end
        default: begin
          data_d.we_src = 1'b1;
          data_d.color  = FillWhite;
        end
      endcase
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/spc_clip_mul.sv
`timescale 1ns / 1ps
// Stage 2: clip box test and row base multiply (y times line pitch).
// Depends on spc_pkg.
module spc_clip_mul import spc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  s1_t  data_i,
  output logic stall_o,
  output logic valid_o,
  output s2_t  data_o,
  input  logic stall_i
);

  s2_t  data_d, data_q;
  logic valid_q;
  logic in_box;
  logic signed [XyW-1:0] left_s, top_s, right_s, bottom_s;
  logic [IdxW-1:0]        y_lo;
  logic [IdxW+PitchW-1:0] prod;

  assign left_s   = $signed({6'd0, cfg_i.clip_left});
  assign top_s    = $signed({6'd0, cfg_i.clip_top});
  assign right_s  = $signed({6'd0, cfg_i.clip_right});
  assign bottom_s = $signed({6'd0, cfg_i.clip_bottom});

  // Inclusive box; an empty box rejects everything
  assign in_box = (data_i.x >= left_s) && (data_i.x <= right_s) &&
                  (data_i.y >= top_s)  && (data_i.y <= bottom_s);

  // Index wraps to 24 bits, so y sign-extended to 24 bits is enough
  assign y_lo = IdxW'(data_i.y);
  assign prod = y_lo * cfg_i.line_pitch;

  always_comb begin
    data_d.we       = data_i.visible && in_box && data_i.we_src;
    data_d.x_lo     = IdxW'(data_i.x);
    data_d.row_base = prod[IdxW-1:0];
    data_d.color    = data_i.color;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/spc_index_out.sv
`timescale 1ns / 1ps
// Stage 3: final index add, zeroing of skipped pixels, output register.
// Depends on spc_pkg.
module spc_index_out import spc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  s2_t        data_i,
  output logic       stall_o,
  output logic       valid_o,
  output pixel_out_t data_o,
  input  logic       stall_i
);

  pixel_out_t data_d, data_q;
  logic       valid_q;

  // Skipped pixels carry zero index and color
  always_comb begin
    data_d.write_enable = data_i.we;
    data_d.write_index  = data_i.we ? (data_i.x_lo + data_i.row_base) : '0;
    data_d.write_color  = data_i.we ? data_i.color : '0;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/sprite_pixel_compositor.sv
`timescale 1ns / 1ps
// Sprite pixel compositor: clip, color key and RGB555/888 write per pixel.
// An input transaction passes the coordinates/color, clip/multiply and index
// add registers in that order. Throughput one pixel per cycle; a stall holds
// only the stages that are full. Reset empties the pipeline and loads the
// clip box 0..639 x 0..479 and pitch 640. Depends on spc_pkg and submodules.
module sprite_pixel_compositor import spc_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // pixel input
  input  logic             in_valid_i,
  input  pixel_in_t        in_data_i,
  output logic             in_stall_o,
  // pixel output
  output logic             out_valid_o,
  output pixel_out_t       out_data_o,
  input  logic             out_stall_i,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  logic s1_valid, s1_stall, s2_valid, s2_stall;
  s1_t  s1_data;
  s2_t  s2_data;

  spc_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .stall_o (in_stall_o),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .stall_i (s1_stall)
  );

  spc_clip_mul u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .stall_o (s1_stall),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .stall_i (s2_stall)
  );

  spc_index_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .stall_o (s2_stall),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .stall_i (out_stall_i)
  );

  // Skipped pixels must come out with zero index and color
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |->
      out_data_o.write_index == '0 && out_data_o.write_color == '0)
    else $error("skipped pixel carries nonzero fields");

  // Back pressure at the input only comes from a full pipe stalled at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && s2_valid && out_valid_o && out_stall_i)
    else $error("input stalled without a full stalled pipe");

  // A stalled first stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && s1_stall |=> s1_valid && $stable(s1_data))
    else $error("stage 1 transaction lost under stall");

  // A stalled row base stage keeps its transaction
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid && s2_stall |=> s2_valid && $stable(s2_data))
    else $error("stage 2 transaction lost under stall");

endmodule

FILE: verif/spc_write_checker.sv
`timescale 1ns / 1ps
// Checker for the sprite pixel compositor. It follows the APB register writes,
// predicts one output transaction per accepted pixel and compares the results.
// Depends on spc_pkg.
module spc_write_checker import spc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  pixel_in_t        in_data_i,
  input  logic             in_stall_i,
  input  logic             out_valid_i,
  input  pixel_out_t       out_data_i,
  input  logic             out_stall_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count_o,
  output int               pending_o
);

  cfg_t       window;
  pixel_out_t expected_writes[$];

  // Clip, key and convert one pixel under the current window
  function automatic pixel_out_t composite_pixel(pixel_in_t p);
    pixel_out_t        res;
    int                px, py, hx, hy, sx, sy;
    logic [15:0]       p16;
    logic [ColorW-1:0] color;
    logic              hit;
    longint            idx;
    res = '0;
    px = $signed(p.pos_x);
    py = $signed(p.pos_y);
    hx = $signed(p.hot_x);
    hy = $signed(p.hot_y);
    sx = px - hx + int'(p.off_x);
    sy = py - hy + int'(p.off_y);
    if (!p.visible) return res;
    if (sx < int'(window.clip_left) || sx > int'(window.clip_right) ||
        sy < int'(window.clip_top) || sy > int'(window.clip_bottom)) return res;
    hit = 1'b1;
    p16 = p.src_pixel[15:0];
    // fills ignore the key; RGB555 keys against the low half only
    if (p.no_data) begin
      color = FillRed;
    end else if (p.pixel_format == FmtRgb555) begin
      hit   = ({16'h0000, p16} != p.key_color);
      color = {8'h00, p16[14:10], 3'b000, p16[9:5], 3'b000, p16[4:0], 3'b000};
    end else if (p.pixel_format == FmtRgb888) begin
      hit   = (p.src_pixel != p.key_color);
      color = p.src_pixel;
    end else begin
      color = FillWhite;
    end
    if (hit) begin
      idx = longint'(sx) + longint'(sy) * longint'(window.line_pitch);
      res.write_enable = 1'b1;
      res.write_index  = idx[IdxW-1:0];
      res.write_color  = color;
    end
    return res;
  endfunction

  // Register shadow, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t want;
    if (!rst_ni) begin
      window.clip_left   = ClipLeftRst;
      window.clip_top    = ClipTopRst;
      window.clip_right  = ClipRightRst;
      window.clip_bottom = ClipBottomRst;
      window.line_pitch  = LinePitchRst;
      expected_writes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_CLIP_LEFT:   window.clip_left   = pwdata[ClipW-1:0];
          REG_CLIP_TOP:    window.clip_top    = pwdata[ClipW-1:0];
          REG_CLIP_RIGHT:  window.clip_right  = pwdata[ClipW-1:0];
          REG_CLIP_BOTTOM: window.clip_bottom = pwdata[ClipW-1:0];
          REG_LINE_PITCH:  window.line_pitch  = pwdata[PitchW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_writes.push_back(composite_pixel(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected write transaction we=%0b idx=%h color=%h", $realtime,
                     out_data_i.write_enable, out_data_i.write_index, out_data_i.write_color);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_writes.pop_front();
          if (out_data_i.write_enable != want.write_enable ||
              out_data_i.write_index != want.write_index ||
              out_data_i.write_color != want.write_color) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch exp we=%0b idx=%h color=%h got we=%0b idx=%h color=%h",
                       $realtime, want.write_enable, want.write_index, want.write_color,
                       out_data_i.write_enable, out_data_i.write_index,
                       out_data_i.write_color);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_writes.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the sprite pixel compositor testbench: clock, reset, pixel and APB
// stimulus, output back-pressure and the verdict. Depends on spc_pkg, the
// compositor and spc_write_checker.
module testbench;
  import spc_pkg::*;

  localparam logic [1:0] FmtReserved = 2'd3;
  localparam int         CycleLimit  = 200000;
  localparam int         HoldCycles  = 120;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  pixel_in_t        in_data;
  logic             in_stall;
  logic             out_valid;
  pixel_out_t       out_data;
  logic             out_stall = 1'b0;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata, prdata;
  logic             pready;

  int fail_count, pending;
  int snd_idle_pct, rcv_idle_pct;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int cur_left, cur_top, cur_right, cur_bottom;

  sprite_pixel_compositor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  spc_write_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_data_i    (in_data),
    .in_stall_i   (in_stall),
    .out_valid_i  (out_valid),
    .out_data_i   (out_data),
    .out_stall_i  (out_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output back-pressure, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  function automatic pixel_in_t mk(input int px, py, hx, hy, ox, oy,
                                   input logic [31:0] src, input logic [1:0] fmt,
                                   input logic [31:0] key, input int nd, vis);
    pixel_in_t p;
    p.pos_x        = px[15:0];
    p.pos_y        = py[15:0];
    p.hot_x        = hx[15:0];
    p.hot_y        = hy[15:0];
    p.off_x        = ox[11:0];
    p.off_y        = oy[11:0];
    p.src_pixel    = src;
    p.pixel_format = fmt;
    p.key_color    = key;
    p.no_data      = nd[0];
    p.visible      = vis[0];
    return p;
  endfunction

  // Screen coordinate mostly inside the box, often on or just past its edges
  function automatic int pick_coord(input int lo, hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && lo <= hi) return int'($urandom_range(hi, lo));
    if (r < 75) return lo - int'($urandom_range(0, 1));
    if (r < 85) return hi + int'($urandom_range(0, 1));
    return int'($urandom_range(0, 4500)) - 200;
  endfunction

  // Split a screen coordinate into position, hotspot and offset
  task automatic place_coord(input int tgt, output logic [15:0] pos, hot,
                             output logic [11:0] off);
    int o, h, q;
    o   = $urandom_range(0, 4095);
    h   = int'($urandom_range(0, 48000)) - 24000;
    q   = tgt - o + h;
    pos = q[15:0];
    hot = h[15:0];
    off = o[11:0];
  endtask

  task automatic random_pixel(output pixel_in_t p);
    int r;
    if ($urandom_range(0, 99) < 15) begin
      p.pos_x = 16'($urandom);
      p.pos_y = 16'($urandom);
      p.hot_x = 16'($urandom);
      p.hot_y = 16'($urandom);
      p.off_x = 12'($urandom);
      p.off_y = 12'($urandom);
    end else begin
      place_coord(pick_coord(cur_left, cur_right), p.pos_x, p.hot_x, p.off_x);
      place_coord(pick_coord(cur_top, cur_bottom), p.pos_y, p.hot_y, p.off_y);
    end
    r = $urandom_range(0, 99);
    if (r < 40) p.pixel_format = FmtRgb555;
    else if (r < 80) p.pixel_format = FmtRgb888;
    else if (r < 90) p.pixel_format = FmtUnknown;
    else p.pixel_format = FmtReserved;
    p.src_pixel = $urandom;
    // key hits, near misses and plain random keys
    r = $urandom_range(0, 99);
    if (r < 35)
      p.key_color = (p.pixel_format == FmtRgb555) ? {16'h0000, p.src_pixel[15:0]} : p.src_pixel;
    else if (r < 45) p.key_color = p.src_pixel;
    else if (r < 50) p.key_color = {16'h0001, p.src_pixel[15:0]};
    else p.key_color = $urandom;
    p.no_data = ($urandom_range(0, 99) < 12);
    p.visible = ($urandom_range(0, 99) >= 8);
  endtask

  // One pixel transaction, with random idle cycles ahead of it
  task automatic send_pixel(input pixel_in_t p);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // APB write; junk above the register width must be dropped
  task automatic apb_write(input reg_idx_e idx, input int val);
    logic [31:0] junk, keep;
    junk = $urandom;
    keep = (idx == REG_LINE_PITCH) ? 32'h0000_1fff : 32'h0000_0fff;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrW'(int'(idx) * 4);
    pwdata  <= (junk & ~keep) | (val & keep);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain the pipe, then load a new clip window and pitch
  task automatic set_window(input int l, t, r, b, pitch);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    apb_write(REG_CLIP_LEFT, l);
    apb_write(REG_CLIP_TOP, t);
    apb_write(REG_CLIP_RIGHT, r);
    apb_write(REG_CLIP_BOTTOM, b);
    apb_write(REG_LINE_PITCH, pitch);
    cur_left   = l;
    cur_top    = t;
    cur_right  = r;
    cur_bottom = b;
  endtask

  // Stimulus and verdict
  initial begin
    pixel_in_t p;
    int        l, t, r, b, pitch;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    snd_idle_pct = 37;
    rcv_idle_pct = 52;
    cur_left     = 0;
    cur_top      = 0;
    cur_right    = 639;
    cur_bottom   = 479;
    rst_ni       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed pixels under the reset window 0..639 x 0..479, pitch 640
    send_pixel(mk(0, 0, 0, 0, 0, 0, 32'h1234_5678, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(600, 400, -39, -79, 0, 0, 32'hdead_7fff, FmtRgb555, 32'h0, 0, 1));
    send_pixel(mk(0, 0, 1, 0, 0, 0, 32'h0000_00ff, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(640, 0, 0, 0, 0, 0, 32'h0000_00ff, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(0, 0, 0, 1, 0, 0, 32'h0000_00ff, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(0, 480, 0, 0, 0, 0, 32'h0000_00ff, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(10, 10, 0, 0, 5, 5, 32'h00aa_bbcc, FmtRgb888, 32'h0, 0, 0));
    // fills ignore the key
    send_pixel(mk(20, 30, 0, 0, 1, 1, 32'h0012_3456, FmtRgb888, 32'h0012_3456, 1, 1));
    send_pixel(mk(21, 30, 0, 0, 0, 0, 32'h0, FmtUnknown, 32'h1, 0, 1));
    send_pixel(mk(22, 30, 0, 0, 0, 0, 32'h55aa_55aa, FmtReserved, 32'h55aa_55aa, 0, 1));
    send_pixel(mk(23, 30, 0, 0, 0, 0, 32'h0055_55aa, FmtReserved, 32'h0055_55aa, 1, 1));
    // RGB555 keying on the low half, a key above 0xffff never matches
    send_pixel(mk(24, 31, 0, 0, 0, 0, 32'habcd_1234, FmtRgb555, 32'h0000_1234, 0, 1));
    send_pixel(mk(25, 31, 0, 0, 0, 0, 32'habcd_1234, FmtRgb555, 32'habcd_1234, 0, 1));
    send_pixel(mk(26, 31, 0, 0, 0, 0, 32'h0000_5678, FmtRgb555, 32'h0001_5678, 0, 1));
    // bit 15 of an RGB555 pixel is dropped
    send_pixel(mk(27, 31, 0, 0, 0, 0, 32'h0000_ffff, FmtRgb555, 32'h0, 0, 1));
    send_pixel(mk(28, 31, 0, 0, 0, 0, 32'h0000_8000, FmtRgb555, 32'h0, 0, 1));
    send_pixel(mk(29, 32, 0, 0, 0, 0, 32'h89ab_cdef, FmtRgb888, 32'h89ab_cdef, 0, 1));
    // coordinate extremes
    send_pixel(mk(32767, 32767, -32768, -32768, 4095, 4095, 32'h1, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(-32768, -32768, 32767, 32767, 0, 0, 32'h1, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(-4000, -4000, -500, -300, 4095, 4095, 32'hffff_ffff, FmtRgb888, 32'h0,
                  0, 1));
    send_pixel(mk(100, 100, 0, 0, 0, 0, 32'h0, FmtRgb888, 32'h0, 0, 1));
    send_pixel(mk(100, 100, 0, 0, 0, 0, 32'h0, FmtRgb888, 32'h1, 1, 0));

    // random pixels over a series of windows and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin l = 0; t = 0; r = 4095; b = 4095; pitch = 4096; end
        1: begin l = 10; t = 20; r = 300; b = 200; pitch = 1; end
        2: begin
          l = $urandom_range(0, 4000); r = l + int'($urandom_range(0, 95));
          t = $urandom_range(0, 4000); b = t + int'($urandom_range(0, 95));
          pitch = $urandom_range(1, 4096);
        end
        3: begin l = 4095; t = 4095; r = 4095; b = 4095; pitch = 0; end
        4: begin l = 300; t = 200; r = 100; b = 100; pitch = 8191; end
        default: begin
          l = $urandom_range(0, 4000); r = l + int'($urandom_range(0, 95));
          t = $urandom_range(0, 4000); b = t + int'($urandom_range(0, 95));
          pitch = 8191;
        end
      endcase
      set_window(l, t, r, b, pitch);
      case (ph / 2)
        0: begin snd_idle_pct = 37; rcv_idle_pct = 52; end
        1: begin snd_idle_pct = 52; rcv_idle_pct = 37; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 105; n++) begin
        if (ph == 0 && n == 30) hold_request <= 1'b1;
        random_pixel(p);
        send_pixel(p);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
